// ----- design/stu_pkg.sv -----
// Package for the synapse trace and weight update block.
// Shared constants, register index codes and the configuration struct.
`default_nettype none
package stu_pkg;

  localparam int unsigned TRACE_W    = 32;
  localparam int unsigned RATE_W     = 29;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned LOG_FRAC   = 24;
  localparam int unsigned EXP_W      = 6;
  localparam int unsigned LOG_W      = EXP_W + LOG_FRAC;
  localparam int unsigned OPND_W     = 33;

  localparam logic [RATE_W-1:0] ONE_Q28 = RATE_W'(1) << 28;
  localparam logic [31:0]       LN2_Q32 = 32'd2977044472;

  localparam logic [RATE_W-1:0] PROB_RATE_RST = '0;
  localparam logic [RATE_W-1:0] ELIG_RATE_RST = '0;
  localparam logic [GAIN_W-1:0] GAIN_RST      = GAIN_W'(256);
  localparam logic [RATE_W-1:0] EPS_LIN_RST   = RATE_W'(26844);
  localparam logic [RATE_W-1:0] EPS_SQ_RST    = RATE_W'(3);

  // stage positions: 0 input, 1 sums, 2 normalize, 3..26 squaring, 27..30 weight
  localparam int unsigned PIPE_DEPTH  = 31;
  localparam int unsigned TRACE_STG   = 4;
  localparam int unsigned TRACE_DELAY = PIPE_DEPTH - 1 - TRACE_STG;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROB_RATE   = 3'd0,
    REG_ELIG_RATE   = 3'd1,
    REG_WEIGHT_GAIN = 3'd2,
    REG_EPS_LIN     = 3'd3,
    REG_EPS_SQ      = 3'd4
  } stu_reg_t;

  typedef struct packed {
    logic [RATE_W-1:0] prob_rate;
    logic [RATE_W-1:0] elig_rate;
    logic [GAIN_W-1:0] weight_gain;
  } stu_cfg_t;

endpackage
`default_nettype wire

// ----- design/stu_in_if.sv -----
// Input channel: one synapse's traces per transaction.
// Depends on stu_pkg.
`default_nettype none
interface stu_in_if;
  logic                         valid;
  logic                         ready;
  logic [stu_pkg::TRACE_W-1:0]  pre_prob;
  logic [stu_pkg::TRACE_W-1:0]  pre_spike_trace;
  logic [stu_pkg::TRACE_W-1:0]  post_prob;
  logic [stu_pkg::TRACE_W-1:0]  post_spike_trace;
  logic [stu_pkg::TRACE_W-1:0]  joint_prob;
  logic [stu_pkg::TRACE_W-1:0]  joint_elig;

  modport source (output valid, pre_prob, pre_spike_trace, post_prob, post_spike_trace,
                  joint_prob, joint_elig, input ready);
  modport sink (input valid, pre_prob, pre_spike_trace, post_prob, post_spike_trace,
                joint_prob, joint_elig, output ready);
endinterface
`default_nettype wire

// ----- design/stu_out_if.sv -----
// Result channel: updated traces and weight per transaction.
// Depends on stu_pkg.
`default_nettype none
interface stu_out_if;
  logic                         valid;
  logic                         ready;
  logic [stu_pkg::TRACE_W-1:0]  new_joint_prob;
  logic [stu_pkg::TRACE_W-1:0]  new_joint_elig;
  logic signed [31:0]           weight;
  logic                         weight_valid;

  modport source (output valid, new_joint_prob, new_joint_elig, weight, weight_valid,
                  input ready);
  modport sink (input valid, new_joint_prob, new_joint_elig, weight, weight_valid,
                output ready);
endinterface
`default_nettype wire

// ----- design/stu_cfg_if.sv -----
// Configuration write channel: register index and write data.
// Depends on stu_pkg.
`default_nettype none
interface stu_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [stu_pkg::CFG_IDX_W-1:0]   index;
  logic [stu_pkg::CFG_DATA_W-1:0]  wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface
`default_nettype wire

// ----- design/stu_log2_lane.sv -----
// log2 of a 33-bit operand in Q.24: normalize stage, then one squaring per stage.
// Depends on stu_pkg.
`default_nettype none
module stu_log2_lane (
  input  wire logic                          clk,
  input  wire logic                          adv,
  input  wire logic [stu_pkg::OPND_W-1:0]    x,
  output logic      [stu_pkg::LOG_W-1:0]     log_val
);
  localparam int unsigned NF = stu_pkg::LOG_FRAC;
  localparam int unsigned EW = stu_pkg::EXP_W;

  logic [EW-1:0]     exp_nxt;
  logic [31:0]       mant_nxt;
  logic [stu_pkg::OPND_W-1:0] shifted;

  logic [31:0]       m_r [0:NF];
  logic [EW-1:0]     e_r [0:NF];
  logic [NF-1:0]     f_r [0:NF];

  always_comb begin
    exp_nxt = '0;
    for (int i = 0; i < stu_pkg::OPND_W; i++) begin
      if (x[i]) exp_nxt = EW'(i);
    end
    shifted  = x << (EW'(32) - exp_nxt);
    mant_nxt = shifted[32:1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_r[0] <= mant_nxt;
      e_r[0] <= exp_nxt;
      f_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < NF; k++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] t;
    assign sq = 64'(m_r[k]) * 64'(m_r[k]);
    assign t  = sq[63:31];
    always_ff @(posedge clk) begin
      if (adv) begin
        e_r[k+1] <= e_r[k];
        f_r[k+1] <= {f_r[k][NF-2:0], t[32]};
        m_r[k+1] <= t[32] ? t[32:1] : t[31:0];
      end
    end
  end

  assign log_val = {e_r[NF], f_r[NF]};
endmodule
`default_nettype wire

// ----- design/stu_weight.sv -----
// Weight back end: log difference, scale by ln 2 and gain, round, saturate.
// Depends on stu_pkg.
`default_nettype none
module stu_weight (
  input  wire logic                          clk,
  input  wire logic                          adv,
  input  wire stu_pkg::stu_cfg_t             cfg,
  input  wire logic [stu_pkg::LOG_W-1:0]     log_a,
  input  wire logic [stu_pkg::LOG_W-1:0]     log_b,
  input  wire logic [stu_pkg::LOG_W-1:0]     log_c,
  output logic signed [31:0]                 weight,
  output logic                               weight_valid
);
  localparam int unsigned MW = stu_pkg::LOG_W + 1;

  logic [MW-1:0] pos, neg;
  logic [MW-1:0] mag_r;
  logic          neg1_r, neg2_r, neg3_r;
  logic [62:0]   lnp_r;
  logic [39:0]   ln_sum;
  logic [54:0]   wp_r;
  logic [55:0]   w_sum;
  logic [31:0]   wm;
  logic [31:0]   w_nxt;
  logic [31:0]   weight_r;
  logic          wvalid_r;

  assign pos = {1'b0, log_a} + (MW'(28) << stu_pkg::LOG_FRAC);
  assign neg = {1'b0, log_b} + {1'b0, log_c};

  assign ln_sum = {1'b0, lnp_r[62:24]} + 40'(lnp_r[23]);
  assign w_sum  = {1'b0, wp_r} + (56'(1) << 23);
  assign wm     = w_sum[55:24];

  always_comb begin
    if (neg3_r) begin
      w_nxt = (wm > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - wm);
    end else begin
      w_nxt = (wm > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : wm;
    end
    if (cfg.prob_rate == '0) w_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg1_r   <= neg > pos;
      mag_r    <= (neg > pos) ? neg - pos : pos - neg;
      neg2_r   <= neg1_r;
      lnp_r    <= 63'(mag_r) * 63'(stu_pkg::LN2_Q32);
      neg3_r   <= neg2_r;
      wp_r     <= 55'(ln_sum[38:0]) * 55'(cfg.weight_gain);
      weight_r <= w_nxt;
      wvalid_r <= cfg.prob_rate != '0;
    end
  end

  assign weight       = weight_r;
  assign weight_valid = wvalid_r;
endmodule
`default_nettype wire

// ----- design/stu_trace.sv -----
// Joint probability and eligibility low-pass steps, delayed to the weight latency.
// Depends on stu_pkg.
`default_nettype none
module stu_trace (
  input  wire logic                          clk,
  input  wire logic                          adv,
  input  wire stu_pkg::stu_cfg_t             cfg,
  input  wire logic [stu_pkg::TRACE_W-1:0]   zi,
  input  wire logic [stu_pkg::TRACE_W-1:0]   zj,
  input  wire logic [stu_pkg::TRACE_W-1:0]   pij,
  input  wire logic [stu_pkg::TRACE_W-1:0]   eij,
  output logic      [stu_pkg::TRACE_W-1:0]   new_prob,
  output logic      [stu_pkg::TRACE_W-1:0]   new_elig
);
  localparam int unsigned RW = stu_pkg::RATE_W;
  localparam int unsigned PW = 32 + RW;
  localparam int unsigned ND = stu_pkg::TRACE_DELAY;

  logic [RW-1:0] rp, re;
  logic [63:0]   prod_r;
  logic [PW-1:0] pa_r, pb_r, ea_r, eb_r;
  logic [31:0]   eij1_r, eij2_r, tgt_r;
  logic [31:0]   np2_r, np3_r, np4_r;
  logic [32:0]   tgt_full;
  logic [PW-1:0] psum, esum;
  logic [31:0]   np_d [0:ND-1];
  logic [31:0]   ne_d [0:ND-1];
  logic [31:0]   ne4_r;

  assign rp = (cfg.prob_rate > stu_pkg::ONE_Q28) ? stu_pkg::ONE_Q28 : cfg.prob_rate;
  assign re = (cfg.elig_rate > stu_pkg::ONE_Q28) ? stu_pkg::ONE_Q28 : cfg.elig_rate;

  assign tgt_full = {1'b0, prod_r[59:28]} + 33'(prod_r[27]);
  assign psum     = pa_r + pb_r + (PW'(1) << 27);
  assign esum     = ea_r + eb_r + (PW'(1) << 27);

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= 64'(zi) * 64'(zj);
      pa_r   <= PW'(pij) * PW'(stu_pkg::ONE_Q28 - rp);
      pb_r   <= PW'(eij) * PW'(rp);
      eij1_r <= eij;

      tgt_r  <= (prod_r[63:60] != '0 || tgt_full[32]) ? 32'hFFFF_FFFF : tgt_full[31:0];
      np2_r  <= psum[59:28];
      eij2_r <= eij1_r;

      ea_r   <= PW'(eij2_r) * PW'(stu_pkg::ONE_Q28 - re);
      eb_r   <= PW'(tgt_r) * PW'(re);
      np3_r  <= np2_r;

      ne4_r  <= esum[59:28];
      np4_r  <= np3_r;

      np_d[0] <= np4_r;
      ne_d[0] <= ne4_r;
      for (int i = 1; i < ND; i++) begin
        np_d[i] <= np_d[i-1];
        ne_d[i] <= ne_d[i-1];
      end
    end
  end

  assign new_prob = np_d[ND-1];
  assign new_elig = ne_d[ND-1];
endmodule
`default_nettype wire

// ----- design/synapse_trace_weight_update.sv -----
// Synapse trace and weight update, one synapse per transaction, 31-stage pipeline.
// Depends on stu_pkg, stu_in_if, stu_out_if, stu_cfg_if, stu_log2_lane, stu_trace, stu_weight.
// Accepts one transaction per cycle; each transaction passes through the input and sum
// stages, the normalize stage, the 24 squaring stages of the log2 lanes and the four weight
// scaling stages. The whole pipeline holds when a result waits; configuration is taken in
// any cycle and must be written only while no transaction is in flight. No clearing pass
// after reset.
`default_nettype none
module synapse_trace_weight_update (
  input  wire logic  clk,
  input  wire logic  rst_n,
  stu_in_if.sink     in_if,
  stu_out_if.source  out_if,
  stu_cfg_if.sink    cfg_if
);
  localparam int unsigned ND = stu_pkg::PIPE_DEPTH;
  localparam int unsigned RW = stu_pkg::RATE_W;

  logic [RW-1:0]             prob_rate_r, elig_rate_r, eps_lin_r, eps_sq_r;
  logic [stu_pkg::GAIN_W-1:0] gain_r;
  stu_pkg::stu_cfg_t         cfg;
  logic [ND-1:0]             vld_r;
  logic                      adv;

  logic [31:0] pi_r, zi_r, pj_r, zj_r, pij_r, eij_r;
  logic [stu_pkg::OPND_W-1:0] a_r, b_r, c_r;
  logic [RW-1:0]             el, es;
  logic [stu_pkg::LOG_W-1:0] log_a, log_b, log_c;

  assign adv          = !vld_r[ND-1] || out_if.ready;
  assign in_if.ready  = adv;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prob_rate_r <= stu_pkg::PROB_RATE_RST;
      elig_rate_r <= stu_pkg::ELIG_RATE_RST;
      gain_r      <= stu_pkg::GAIN_RST;
      eps_lin_r   <= stu_pkg::EPS_LIN_RST;
      eps_sq_r    <= stu_pkg::EPS_SQ_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        stu_pkg::REG_PROB_RATE:   prob_rate_r <= cfg_if.wdata[RW-1:0];
        stu_pkg::REG_ELIG_RATE:   elig_rate_r <= cfg_if.wdata[RW-1:0];
        stu_pkg::REG_WEIGHT_GAIN: gain_r      <= cfg_if.wdata[stu_pkg::GAIN_W-1:0];
        stu_pkg::REG_EPS_LIN:     eps_lin_r   <= cfg_if.wdata[RW-1:0];
        stu_pkg::REG_EPS_SQ:      eps_sq_r    <= cfg_if.wdata[RW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.prob_rate   = prob_rate_r;
  assign cfg.elig_rate   = elig_rate_r;
  assign cfg.weight_gain = gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[ND-2:0], in_if.valid};
    end
  end

  assign el = (eps_lin_r == '0) ? RW'(1) : eps_lin_r;
  assign es = (eps_sq_r == '0) ? RW'(1) : eps_sq_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pi_r  <= in_if.pre_prob;
      zi_r  <= in_if.pre_spike_trace;
      pj_r  <= in_if.post_prob;
      zj_r  <= in_if.post_spike_trace;
      pij_r <= in_if.joint_prob;
      eij_r <= in_if.joint_elig;
      a_r   <= {1'b0, pij_r} + stu_pkg::OPND_W'(es);
      b_r   <= {1'b0, pi_r} + stu_pkg::OPND_W'(el);
      c_r   <= {1'b0, pj_r} + stu_pkg::OPND_W'(el);
    end
  end

  stu_log2_lane u_log_a (.clk(clk), .adv(adv), .x(a_r), .log_val(log_a));
  stu_log2_lane u_log_b (.clk(clk), .adv(adv), .x(b_r), .log_val(log_b));
  stu_log2_lane u_log_c (.clk(clk), .adv(adv), .x(c_r), .log_val(log_c));

  stu_weight u_weight (
    .clk(clk), .adv(adv), .cfg(cfg),
    .log_a(log_a), .log_b(log_b), .log_c(log_c),
    .weight(out_if.weight), .weight_valid(out_if.weight_valid)
  );

  stu_trace u_trace (
    .clk(clk), .adv(adv), .cfg(cfg),
    .zi(zi_r), .zj(zj_r), .pij(pij_r), .eij(eij_r),
    .new_prob(out_if.new_joint_prob), .new_elig(out_if.new_joint_elig)
  );

  assign out_if.valid = vld_r[ND-1];
endmodule
`default_nettype wire
